// ===== hw/rtl/knn_pkg.sv =====
`default_nettype none

package knn_pkg;

  // Defaults for the top-level parameters
  localparam int DefNumPoints    = 1024;
  localparam int DefMaxNeighbors = 16;

  // Fixed field widths
  localparam int IdWidth      = 10;
  localparam int DistWidth    = 32;
  localparam int SlotWidth    = 4;
  localparam int CountWidth   = 5;
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;

  // Operation codes
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register word indexes
  localparam logic REG_NEIGHBOR_COUNT = 1'b0;

  localparam logic [CountWidth-1:0] NeighborCountReset = CountWidth'(8);

  // One list entry as stored in memory
  typedef struct packed {
    logic                 fresh;
    logic [DistWidth-1:0] distance;
    logic [IdWidth-1:0]   id;
  } entry_t;

  localparam int EntryWidth = $bits(entry_t);

  // Status of one processed word
  typedef struct packed {
    logic write;
    logic updated;
    logic read_valid;
  } upd_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/knn_ram.sv =====
`default_nettype none

module knn_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/knn_row_update.sv =====
`default_nettype none

module knn_row_update #(
  parameter int MaxNeighbors = knn_pkg::DefMaxNeighbors,
  parameter int CntW         = $clog2(MaxNeighbors + 1)
) (
  input  wire logic                                     op_i,
  input  wire logic                                     in_range_i,
  input  wire knn_pkg::entry_t [MaxNeighbors-1:0]       row_i,
  input  wire logic [CntW-1:0]                          fill_i,
  input  wire logic [CntW-1:0]                          count_i,
  input  wire logic [knn_pkg::IdWidth-1:0]              nid_i,
  input  wire logic [knn_pkg::DistWidth-1:0]            dist_i,
  input  wire logic [knn_pkg::SlotWidth-1:0]            slot_i,
  output      knn_pkg::entry_t [MaxNeighbors-1:0]       row_o,
  output      logic [CntW-1:0]                          fill_o,
  output      knn_pkg::entry_t                          rd_entry_o,
  output      knn_pkg::upd_status_t                     status_o
);

  import knn_pkg::*;

  logic [CntW-1:0]         f;
  logic [CntW-1:0]         ins;
  logic                    found;
  logic [MaxNeighbors-1:0] dup;
  logic                    dup_hit;
  logic [DistWidth-1:0]    row_ceiling;
  logic                    considered;
  logic                    accept;
  logic                    slot_ok;
  entry_t                  new_entry;
  entry_t                  sel_entry;

  // Scan the list: insertion point, duplicates, current maximum
  always_comb begin
    f           = (fill_i < count_i) ? fill_i : count_i;
    row_ceiling = '1;
    ins         = f;
    found       = 1'b0;
    dup         = '0;
    dup_hit     = 1'b0;
    for (int i = 0; i < MaxNeighbors; i++) begin
      if (CntW'(i + 1) == fill_i) begin
        row_ceiling = row_i[i].distance;
      end
      dup[i] = (CntW'(i) < f) && (row_i[i].id == nid_i);
      if (!found && (((CntW'(i) < f) && (row_i[i].distance > dist_i)) ||
                     (CntW'(i) == f))) begin
        ins   = CntW'(i);
        found = 1'b1;
      end
    end
    for (int i = 0; i < MaxNeighbors; i++) begin
      if (dup[i] && (CntW'(i) <= ins)) begin
        dup_hit = 1'b1;
      end
    end
    considered = (row_ceiling > dist_i) || (f < count_i);
    accept     = in_range_i && (op_i == OP_OFFER) && considered && !dup_hit &&
                 (ins < count_i);
  end

  // Build the shifted row with the candidate in place
  always_comb begin
    new_entry.fresh    = 1'b1;
    new_entry.distance = dist_i;
    new_entry.id       = nid_i;
    for (int j = 0; j < MaxNeighbors; j++) begin
      if ((CntW'(j) >= count_i) || (CntW'(j) < ins)) begin
        row_o[j] = row_i[j];
      end else if (CntW'(j) == ins) begin
        row_o[j] = new_entry;
      end else begin
        row_o[j] = row_i[(j == 0) ? 0 : j - 1];
      end
    end
    fill_o = (f < count_i) ? f + CntW'(1) : count_i;
  end

  // Select the entry for a read
  always_comb begin
    slot_ok   = (int'(slot_i) < MaxNeighbors) && (int'(slot_i) < int'(fill_i));
    sel_entry = '0;
    for (int i = 0; i < MaxNeighbors; i++) begin
      if (int'(slot_i) == i) begin
        sel_entry = row_i[i];
      end
    end
    rd_entry_o = '0;
    if (in_range_i && (op_i == OP_READ) && slot_ok) begin
      rd_entry_o = sel_entry;
    end
  end

  assign status_o.write      = accept;
  assign status_o.updated    = accept;
  assign status_o.read_valid = in_range_i && (op_i == OP_READ) && slot_ok;

endmodule

`default_nettype wire

// ===== hw/rtl/knn_list_sorted_insert.sv =====
`default_nettype none

// Sorted k-nearest-neighbor list store. Each point owns one list of up to
// neighbor_count entries (id, distance, new mark) kept in ascending distance
// order. An offer word inserts a candidate at its sorted place and a read
// word returns one entry; every input word yields exactly one result word.
// Each list, together with its fill count, is one row of a single memory,
// so a word is handled in order: the row is read when the word is taken,
// then all slots are compared in parallel, the shifted row is written back
// and the result register is loaded. A new word is taken only once the
// previous result leaves the output, at the earliest in the same cycle as
// that result is taken. After reset the block sweeps the memory to clear
// all fill counts, one row a cycle; no input word is taken during the
// sweep, while configuration writes are accepted throughout.
module knn_list_sorted_insert #(
  parameter int NUM_POINTS    = knn_pkg::DefNumPoints,
  parameter int MAX_NEIGHBORS = knn_pkg::DefMaxNeighbors
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [knn_pkg::ApbAddrWidth-1:0]    paddr,
  input  wire logic [knn_pkg::ApbDataWidth-1:0]    pwdata,
  output      logic [knn_pkg::ApbDataWidth-1:0]    prdata,
  output      logic                                pready,
  // Input words
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic [knn_pkg::IdWidth-1:0]         list_index_i,
  input  wire logic [knn_pkg::IdWidth-1:0]         neighbor_id_i,
  input  wire logic [knn_pkg::DistWidth-1:0]       distance_i,
  input  wire logic [knn_pkg::SlotWidth-1:0]       slot_index_i,
  // Result words
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic                                updated_o,
  output      logic [knn_pkg::IdWidth-1:0]         read_id_o,
  output      logic [knn_pkg::DistWidth-1:0]       read_distance_o,
  output      logic                                read_new_o,
  output      logic                                read_valid_o
);

  import knn_pkg::*;

  localparam int IdxW  = $clog2(NUM_POINTS);
  localparam int CntW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int RowW  = MAX_NEIGHBORS * EntryWidth;
  localparam int MemW  = CntW + RowW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [IdxW-1:0]        clr_q, clr_d;
  logic [CountWidth-1:0]  count_q;
  logic [CntW-1:0]        eff_count;

  logic                   op_q;
  logic [IdxW-1:0]        idx_q;
  logic                   in_range_q;
  logic [IdWidth-1:0]     nid_q;
  logic [DistWidth-1:0]   dist_q;
  logic [SlotWidth-1:0]   slot_q;

  logic                   out_valid_q;
  logic                   updated_q;
  logic [IdWidth-1:0]     rid_q;
  logic [DistWidth-1:0]   rdist_q;
  logic                   rnew_q;
  logic                   rvalid_q;

  logic                   in_fire;
  logic                   cfg_write;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [MemW-1:0]        mem_wdata;
  logic [MemW-1:0]        mem_rdata;

  entry_t [MAX_NEIGHBORS-1:0] row_rd;
  entry_t [MAX_NEIGHBORS-1:0] row_wr;
  logic [CntW-1:0]            fill_rd;
  logic [CntW-1:0]            fill_wr;
  entry_t                     rd_entry;
  upd_status_t                status;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= NeighborCountReset;
    end else if (cfg_write && (paddr[2] == REG_NEIGHBOR_COUNT)) begin
      count_q <= pwdata[CountWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NEIGHBOR_COUNT) begin
      prdata = ApbDataWidth'(count_q);
    end
  end

  // Clamp the count to the supported range
  always_comb begin
    if (count_q == '0) begin
      eff_count = CntW'(1);
    end else if (int'(count_q) > MAX_NEIGHBORS) begin
      eff_count = CntW'(MAX_NEIGHBORS);
    end else begin
      eff_count = CntW'(count_q);
    end
  end

  // Input handshake: take a word when idle and the result slot frees up
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IdxW'(1);
        if (int'(clr_q) == NUM_POINTS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= operation_i;
      idx_q      <= IdxW'(list_index_i);
      in_range_q <= (int'(list_index_i) < NUM_POINTS);
      nid_q      <= neighbor_id_i;
      dist_q     <= distance_i;
      slot_q     <= slot_index_i;
    end
  end

  // Row memory: fill count on top, entries below
  assign fill_rd = mem_rdata[MemW-1 -: CntW];
  assign row_rd  = mem_rdata[RowW-1:0];

  knn_row_update #(
    .MaxNeighbors (MAX_NEIGHBORS),
    .CntW         (CntW)
  ) u_row_update (
    .op_i       (op_q),
    .in_range_i (in_range_q),
    .row_i      (row_rd),
    .fill_i     (fill_rd),
    .count_i    (eff_count),
    .nid_i      (nid_q),
    .dist_i     (dist_q),
    .slot_i     (slot_q),
    .row_o      (row_wr),
    .fill_o     (fill_wr),
    .rd_entry_o (rd_entry),
    .status_o   (status)
  );

  // Clear rows after reset, write back updated rows
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {fill_wr, row_wr};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_BUSY) begin
      mem_we = status.write;
    end
  end

  knn_ram #(
    .Width (MemW),
    .Depth (NUM_POINTS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (IdxW'(list_index_i)),
    .rdata_o (mem_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_BUSY) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUSY) begin
      updated_q <= status.updated;
      rid_q     <= rd_entry.id;
      rdist_q   <= rd_entry.distance;
      rnew_q    <= rd_entry.fresh;
      rvalid_q  <= status.read_valid;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign updated_o       = updated_q;
  assign read_id_o       = rid_q;
  assign read_distance_o = rdist_q;
  assign read_new_o      = rnew_q;
  assign read_valid_o    = rvalid_q;

  // Checks
  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_write_only_offer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_BUSY) && mem_we) |-> (op_q == OP_OFFER) && in_range_q)
    else $error("row written back for a read or out-of-range word");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY) |-> !out_valid_q)
    else $error("result register overwritten");

  a_update_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && updated_o) |-> !read_valid_o)
    else $error("result marks both update and read");

endmodule

`default_nettype wire
